@@ rtl/dcc_apt_pkg.sv @@
// shared types, constants and register defaults for the dcc accessory packet transmitter
// no dependencies; imported by every module of the block

package dcc_apt_pkg;

    // packet store and field widths
    localparam int PKT_BYTES   = 4;
    localparam int IDX_W       = $clog2(PKT_BYTES);
    localparam int LEN_W       = 3;
    localparam int INTERVAL_W  = 16;
    localparam int PRE_W       = 6;
    localparam int RPT_W       = 4;
    localparam int ADDR_W      = 11;
    localparam int LED_W       = 3;
    localparam int CFG_IDX_W   = 2;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register defaults after reset
    localparam logic [INTERVAL_W-1:0] ONE_INTERVAL_RST  = 16'd58;
    localparam logic [INTERVAL_W-1:0] ZERO_INTERVAL_RST = 16'd100;
    localparam logic [PRE_W-1:0]      PREAMBLE_RST      = 6'd16;
    localparam logic [RPT_W-1:0]      REPEAT_RST        = 4'd3;

    // accessory packet bit patterns
    localparam logic [7:0] ACC_MARK      = 8'h80;
    localparam logic [7:0] TURNOUT_FIXED = 8'h88;
    localparam logic [7:0] FIRST_BIT     = 8'h80;

    // data byte counts of the two packet kinds (checksum comes on top)
    localparam logic [LEN_W-1:0] TURNOUT_DATA_LEN = 3'd2;
    localparam logic [LEN_W-1:0] SIGNAL_DATA_LEN  = 3'd3;

    // operation codes on the input stream
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_TURNOUT = 2'd1,
        OP_SIGNAL  = 2'd2,
        OP_NONE    = 2'd3
    } t_op;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ONE_INTERVAL  = 2'd0,
        CFG_ZERO_INTERVAL = 2'd1,
        CFG_PREAMBLE_BITS = 2'd2,
        CFG_REPEAT_COUNT  = 2'd3
    } t_cfg_idx;

    // classified command kinds handed to the back end
    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_LOAD   = 2'd1,
        KIND_IGNORE = 2'd2
    } t_kind;

    // one classified command
    typedef struct packed {
        t_kind                      kind;
        logic [PKT_BYTES-1:0][7:0]  bytes;
        logic [LEN_W-1:0]           len;
    } t_cmd;

    // one result transaction
    typedef struct packed {
        logic                  pending;
        logic                  accepted;
        logic [INTERVAL_W-1:0] timer;
        logic                  rail;
    } t_result;

endpackage

@@ rtl/dcc_accessory_packet_transmitter.sv @@
// top level of the dcc accessory packet transmitter
// depends on dcc_apt_pkg, dcc_apt_front, dcc_apt_queue and dcc_apt_back

// Takes one transaction per clock cycle on the slave stream when the downstream side keeps
// up: every tick or load produces exactly one result transaction; once taken, it passes
// through the two-entry command queue and then the result register. The back end sets the
// rate, applying one command per cycle to the bit sequencer state while its result register
// is free or being read; a stalled master side fills the queue and then holds s_axis_tready
// low. Loads are refused (load_accepted low) while a packet is still being sent or repeated.
// Configuration writes take effect on the next cycle and are meant for idle periods only.

module dcc_accessory_packet_transmitter
    import dcc_apt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [INTERVAL_W-1:0] i_cfg_data,
    // command stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [15:0]           s_axis_tdata,  // device_address[10:0], direction, led_index[2:0], led_on
    input  logic [1:0]            s_axis_tuser,  // operation[1:0]
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata   // rail_level, timer_value[15:0], load_accepted, packet_pending, zero fill
);

    t_cmd    w_front_cmd;
    t_cmd    w_head_cmd;
    logic    w_full;
    logic    w_empty;
    logic    w_pop;
    logic    w_push;
    t_result w_res;

    assign s_axis_tready = !w_full;
    assign w_push        = s_axis_tvalid && !w_full;

    // classification and packet building
    dcc_apt_front u_front (
        .i_op      (s_axis_tuser),
        .i_addr    (s_axis_tdata[10:0]),
        .i_dir     (s_axis_tdata[11]),
        .i_led_idx (s_axis_tdata[14:12]),
        .i_led_on  (s_axis_tdata[15]),
        .o_cmd     (w_front_cmd)
    );

    // decoupling queue
    dcc_apt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_head_cmd)
    );

    // sequencer and result register
    dcc_apt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (!w_empty),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_res_valid (m_axis_tvalid),
        .o_res       (w_res),
        .i_res_ready (m_axis_tready)
    );

    // result packing, first field in the lowest bit
    assign m_axis_tdata = {5'b00000, w_res.pending, w_res.accepted, w_res.timer, w_res.rail};

endmodule

@@ rtl/dcc_apt_front.sv @@
// front end: decodes the operation and builds packet bytes plus xor checksum
// depends on dcc_apt_pkg

module dcc_apt_front
    import dcc_apt_pkg::*;
(
    input  logic [1:0]        i_op,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic              i_dir,
    input  logic [LED_W-1:0]  i_led_idx,
    input  logic              i_led_on,
    output t_cmd              o_cmd
);

    logic [15:0] w_t;
    logic [7:0]  w_b0;
    logic [7:0]  w_b1;
    logic [7:0]  w_b2;
    t_op         w_op;

    assign w_op = t_op'(i_op);
    // turnout temporary: address with direction in bit 15, minus one
    assign w_t  = {i_dir, 4'b0000, i_addr} - 16'd1;

    // byte assembly per command kind
    always_comb begin
        o_cmd       = '0;
        o_cmd.kind  = KIND_IGNORE;
        w_b0        = '0;
        w_b1        = '0;
        w_b2        = '0;
        unique case (w_op)
            OP_TICK: begin
                o_cmd.kind = KIND_TICK;
            end
            OP_TURNOUT: begin
                w_b0 = ACC_MARK | {2'b00, w_t[7:2] + 6'd1};
                w_b1 = {~w_t[11:8], 4'b0000} | TURNOUT_FIXED | {5'b00000, w_t[1:0], i_dir};
                o_cmd.kind     = KIND_LOAD;
                o_cmd.bytes[0] = w_b0;
                o_cmd.bytes[1] = w_b1;
                o_cmd.bytes[2] = w_b0 ^ w_b1;
                o_cmd.len      = TURNOUT_DATA_LEN + 3'd1;
            end
            OP_SIGNAL: begin
                w_b0 = ACC_MARK | {2'b00, i_addr[5:0]};
                w_b1 = {1'b0, i_addr[10:8], 1'b0, i_addr[7:6], 1'b1};
                w_b2 = ACC_MARK | {4'b0000, i_led_on, i_led_idx};
                o_cmd.kind     = KIND_LOAD;
                o_cmd.bytes[0] = w_b0;
                o_cmd.bytes[1] = w_b1;
                o_cmd.bytes[2] = w_b2;
                o_cmd.bytes[3] = w_b0 ^ w_b1 ^ w_b2;
                o_cmd.len      = SIGNAL_DATA_LEN + 3'd1;
            end
            OP_NONE: begin
                o_cmd.kind = KIND_IGNORE;
            end
            default: begin
                o_cmd.kind = KIND_IGNORE;
            end
        endcase
    end

endmodule

@@ rtl/dcc_apt_queue.sv @@
// short command queue between front and back end
// depends on dcc_apt_pkg

module dcc_apt_queue
    import dcc_apt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_data
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    // never written when full, never read when empty
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue read while empty");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + QCNT_W'(1)))
        else $error("queue count did not follow a push");

endmodule

@@ rtl/dcc_apt_back.sv @@
// back end: configuration registers, bit sequencer state and result register
// depends on dcc_apt_pkg

module dcc_apt_back
    import dcc_apt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [INTERVAL_W-1:0] i_cfg_data,
    input  logic                  i_cmd_valid,
    input  t_cmd                  i_cmd,
    output logic                  o_pop,
    output logic                  o_res_valid,
    output t_result               o_res,
    input  logic                  i_res_ready
);

    // configuration
    logic [INTERVAL_W-1:0] r_one_interval;
    logic [INTERVAL_W-1:0] r_zero_interval;
    logic [PRE_W-1:0]      r_preamble_bits;
    logic [RPT_W-1:0]      r_repeat_count;

    // sequencer state
    logic                      r_half_phase, n_half_phase;
    logic [INTERVAL_W-1:0]     r_bit_interval, n_bit_interval;
    logic [PKT_BYTES-1:0][7:0] r_pkt, n_pkt;
    logic [LEN_W-1:0]          r_len, n_len;
    logic [LEN_W-1:0]          r_byte_idx, n_byte_idx;
    logic [7:0]                r_bit_mask, n_bit_mask;
    logic [PRE_W-1:0]          r_preamble_left, n_preamble_left;
    logic [RPT_W-1:0]          r_repeats_left, n_repeats_left;
    logic                      r_ready, n_ready;

    // result register
    logic    r_res_valid;
    t_result r_res, n_res;

    logic [7:0] w_cur;
    logic [7:0] w_mask_next;

    assign o_pop       = i_cmd_valid && (!r_res_valid || i_res_ready);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // current packet byte
    assign w_cur = (r_byte_idx < LEN_W'(PKT_BYTES)) ? r_pkt[r_byte_idx[IDX_W-1:0]] : 8'h00;
    assign w_mask_next = r_bit_mask >> 1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_interval  <= ONE_INTERVAL_RST;
            r_zero_interval <= ZERO_INTERVAL_RST;
            r_preamble_bits <= PREAMBLE_RST;
            r_repeat_count  <= REPEAT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_ONE_INTERVAL:  r_one_interval  <= i_cfg_data;
                CFG_ZERO_INTERVAL: r_zero_interval <= i_cfg_data;
                CFG_PREAMBLE_BITS: r_preamble_bits <= i_cfg_data[PRE_W-1:0];
                CFG_REPEAT_COUNT:  r_repeat_count  <= i_cfg_data[RPT_W-1:0];
                default: ;
            endcase
        end
    end

    // next state and result for the command at the queue head
    always_comb begin
        n_half_phase    = r_half_phase;
        n_bit_interval  = r_bit_interval;
        n_pkt           = r_pkt;
        n_len           = r_len;
        n_byte_idx      = r_byte_idx;
        n_bit_mask      = r_bit_mask;
        n_preamble_left = r_preamble_left;
        n_repeats_left  = r_repeats_left;
        n_ready         = r_ready;
        n_res           = '0;

        unique case (i_cmd.kind)
            KIND_TICK: begin
                n_res.timer = r_bit_interval;
                if (r_half_phase) begin
                    n_res.rail   = 1'b1;
                    n_half_phase = 1'b0;
                end else begin
                    n_half_phase   = 1'b1;
                    n_bit_interval = r_one_interval;
                    // pick the next bit: preamble, start bit, data bit or packet end
                    if (r_preamble_left != '0) begin
                        n_preamble_left = r_preamble_left - PRE_W'(1);
                    end else if (r_ready) begin
                        if (r_byte_idx != r_len) begin
                            if (r_bit_mask == '0) begin
                                n_bit_interval = r_zero_interval;
                                n_bit_mask     = FIRST_BIT;
                            end else begin
                                n_bit_interval = ((w_cur & r_bit_mask) != '0) ?
                                                 r_one_interval : r_zero_interval;
                                n_bit_mask = w_mask_next;
                                if (w_mask_next == '0) begin
                                    n_byte_idx = r_byte_idx + LEN_W'(1);
                                end
                            end
                        end else begin
                            n_preamble_left = r_preamble_bits;
                            n_byte_idx      = '0;
                            if (r_repeats_left != '0) begin
                                n_repeats_left = r_repeats_left - RPT_W'(1);
                            end else begin
                                n_len   = '0;
                                n_ready = 1'b0;
                            end
                        end
                    end
                end
            end
            KIND_LOAD: begin
                if (!r_ready) begin
                    n_res.accepted = 1'b1;
                    n_pkt          = i_cmd.bytes;
                    n_len          = i_cmd.len;
                    n_byte_idx     = '0;
                    n_bit_mask     = '0;
                    n_repeats_left = r_repeat_count;
                    n_ready        = 1'b1;
                end
            end
            KIND_IGNORE: ;
            default: ;
        endcase
        n_res.pending = n_ready;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_phase    <= 1'b0;
            r_bit_interval  <= ONE_INTERVAL_RST;
            r_len           <= '0;
            r_byte_idx      <= '0;
            r_bit_mask      <= '0;
            r_preamble_left <= PREAMBLE_RST;
            r_repeats_left  <= '0;
            r_ready         <= 1'b0;
            r_res_valid     <= 1'b0;
        end else begin
            if (o_pop) begin
                r_half_phase    <= n_half_phase;
                r_bit_interval  <= n_bit_interval;
                r_len           <= n_len;
                r_byte_idx      <= n_byte_idx;
                r_bit_mask      <= n_bit_mask;
                r_preamble_left <= n_preamble_left;
                r_repeats_left  <= n_repeats_left;
                r_ready         <= n_ready;
                r_res_valid     <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    // packet bytes and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_pkt <= n_pkt;
            r_res <= n_res;
        end
    end

    a_idle_no_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ready |-> (r_len == '0))
        else $error("packet length left over while no packet pending");

    a_length_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> ((r_len == TURNOUT_DATA_LEN + 3'd1) || (r_len == SIGNAL_DATA_LEN + 3'd1)))
        else $error("pending packet has an illegal length");

    a_index_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_byte_idx <= r_len))
        else $error("byte index ran past the packet");

    a_load_sets_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && (i_cmd.kind == KIND_LOAD) && !r_ready) |=> (r_ready && r_res.accepted))
        else $error("accepted load did not mark a packet pending");

endmodule
